### hw/rtl/complex_arith_unit_macros.svh
// Assertion helpers used by complex_arith_unit.sv to check this block.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cau_pkg.sv
`default_nettype none
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QBITS = 34;

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_DIST = 3'd4;

  localparam logic [2:0] KIND_SUM  = 3'd0;
  localparam logic [2:0] KIND_MUL  = 3'd1;
  localparam logic [2:0] KIND_DIV  = 3'd2;
  localparam logic [2:0] KIND_DIST = 3'd3;
  localparam logic [2:0] KIND_ZERO = 3'd4;
  localparam logic [2:0] KIND_DZ   = 3'd5;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic               divide_by_zero;
    logic               overflow;
  } cau_out_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               ovf;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } cau_mid_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } cau_sat_t;

  function automatic cau_sat_t cau_sat(input logic neg, input logic big,
                                       input logic [QBITS-1:0] mag);
    cau_sat_t r;
    r.ovf = 1'b0;
    r.val = mag[31:0];
    if (!neg) begin
      if (big || mag > QBITS'(32'h7FFF_FFFF)) begin
        r.ovf = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end
    end else begin
      if (big || mag > QBITS'(32'h8000_0000)) begin
        r.ovf = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = ~mag[31:0] + 32'd1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/cau_fifo.sv
`default_nettype none
module cau_fifo #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule
`default_nettype wire

### hw/rtl/cau_front.sv
`default_nettype none
module cau_front import cau_pkg::*; (
  input  cau_in_t  item_i,
  output cau_mid_t item_o
);

  logic signed [32:0] sr;
  logic signed [32:0] si;
  logic               is_sub;
  logic               ovf_r_part;
  logic               ovf_i_part;
  logic [31:0]        re_sat;
  logic [31:0]        im_sat;

  assign is_sub = (item_i.mode == MODE_SUB);
  assign sr = is_sub ? 33'(item_i.a_real) - 33'(item_i.b_real)
                     : 33'(item_i.a_real) + 33'(item_i.b_real);
  assign si = is_sub ? 33'(item_i.a_imag) - 33'(item_i.b_imag)
                     : 33'(item_i.a_imag) + 33'(item_i.b_imag);
  assign ovf_r_part = sr[32] != sr[31];
  assign ovf_i_part = si[32] != si[31];
  assign re_sat = ovf_r_part ? (sr[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sr[31:0];
  assign im_sat = ovf_i_part ? (si[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : si[31:0];

  always_comb begin
    item_o.kind = KIND_ZERO;
    item_o.ovf  = 1'b0;
    item_o.ar   = item_i.a_real;
    item_o.ai   = item_i.a_imag;
    item_o.br   = item_i.b_real;
    item_o.bi   = item_i.b_imag;
    item_o.dx   = 33'(item_i.a_real) - 33'(item_i.b_real);
    item_o.dy   = 33'(item_i.a_imag) - 33'(item_i.b_imag);
    unique case (item_i.mode)
      MODE_ADD, MODE_SUB: begin
        item_o.kind = KIND_SUM;
        item_o.ovf  = ovf_r_part || ovf_i_part;
        item_o.ar   = re_sat;
        item_o.ai   = im_sat;
      end
      MODE_MUL: item_o.kind = KIND_MUL;
      MODE_DIV: begin
        if (item_i.b_real == 32'sd0 && item_i.b_imag == 32'sd0) item_o.kind = KIND_DZ;
        else item_o.kind = KIND_DIV;
      end
      MODE_DIST: item_o.kind = KIND_DIST;
      default:   item_o.kind = KIND_ZERO;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/cau_back.sv
`default_nettype none
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  cau_mid_t in_item,
  output logic     out_valid,
  output cau_out_t out_item
);

  localparam int NW     = 64 + FRAC_BITS;
  localparam int SREM_W = QBITS + 2;
  localparam int TS_W   = QBITS + 4;
  localparam int SQ_W   = 2 * QBITS;

  typedef struct packed {
    logic [2:0]        kind;
    logic              ovf;
    logic [31:0]       pr;
    logic [31:0]       pi;
    logic              negr;
    logic              negi;
    logic              bigr;
    logic              bigi;
    logic [63:0]       den;
    logic [63:0]       remr;
    logic [QBITS-1:0]  qnr;
    logic [63:0]       remi;
    logic [QBITS-1:0]  qni;
    logic [SQ_W-1:0]   sq;
    logic [SREM_W-1:0] srem;
    logic [QBITS-1:0]  root;
  } it_t;

  function automatic it_t it_step(input it_t c);
    it_t            n;
    logic [64:0]    tr;
    logic [64:0]    ti;
    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] trial;
    n = c;
    tr = {c.remr, c.qnr[QBITS-1]};
    if (tr >= {1'b0, c.den}) begin
      n.remr = 64'(tr - {1'b0, c.den});
      n.qnr  = {c.qnr[QBITS-2:0], 1'b1};
    end else begin
      n.remr = tr[63:0];
      n.qnr  = {c.qnr[QBITS-2:0], 1'b0};
    end
    ti = {c.remi, c.qni[QBITS-1]};
    if (ti >= {1'b0, c.den}) begin
      n.remi = 64'(ti - {1'b0, c.den});
      n.qni  = {c.qni[QBITS-2:0], 1'b1};
    end else begin
      n.remi = ti[63:0];
      n.qni  = {c.qni[QBITS-2:0], 1'b0};
    end
    ts    = {c.srem, c.sq[SQ_W-1 -: 2]};
    trial = TS_W'({c.root, 2'b01});
    if (ts >= trial) begin
      n.srem = SREM_W'(ts - trial);
      n.root = {c.root[QBITS-2:0], 1'b1};
    end else begin
      n.srem = ts[SREM_W-1:0];
      n.root = {c.root[QBITS-2:0], 1'b0};
    end
    n.sq = {c.sq[SQ_W-3:0], 2'b00};
    return n;
  endfunction

  logic               v1_r;
  logic [2:0]         kind1_r;
  logic               ovf1_r;
  logic [31:0]        pr1_r;
  logic [31:0]        pi1_r;
  logic signed [63:0] p0_r;
  logic signed [63:0] p1_r;
  logic signed [63:0] p2_r;
  logic signed [63:0] p3_r;
  logic signed [65:0] p4_r;
  logic signed [65:0] p5_r;
  logic signed [32:0] e0;
  logic signed [32:0] e1;

  assign e0 = (in_item.kind == KIND_DIST) ? in_item.dx : 33'(in_item.br);
  assign e1 = (in_item.kind == KIND_DIST) ? in_item.dy : 33'(in_item.bi);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r <= in_item.kind;
      ovf1_r  <= in_item.ovf;
      pr1_r   <= in_item.ar;
      pi1_r   <= in_item.ai;
      p0_r    <= 64'(in_item.ar) * 64'(in_item.br);
      p1_r    <= 64'(in_item.ai) * 64'(in_item.bi);
      p2_r    <= 64'(in_item.ar) * 64'(in_item.bi);
      p3_r    <= 64'(in_item.ai) * 64'(in_item.br);
      p4_r    <= 66'(e0) * 66'(e0);
      p5_r    <= 66'(e1) * 66'(e1);
    end
  end

  logic signed [65:0] tr;
  logic signed [65:0] ti;
  logic               v2_r;
  logic [2:0]         kind2_r;
  logic               ovf2_r;
  logic [31:0]        pr2_r;
  logic [31:0]        pi2_r;
  logic               negr2_r;
  logic               negi2_r;
  logic [63:0]        magr2_r;
  logic [63:0]        magi2_r;
  logic [65:0]        s2_r;

  always_comb begin
    if (kind1_r == KIND_MUL) begin
      tr = 66'(p0_r) - 66'(p1_r);
      ti = 66'(p2_r) + 66'(p3_r);
    end else begin
      tr = 66'(p0_r) + 66'(p1_r);
      ti = 66'(p3_r) - 66'(p2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind2_r <= kind1_r;
      ovf2_r  <= ovf1_r;
      pr2_r   <= pr1_r;
      pi2_r   <= pi1_r;
      negr2_r <= tr[65];
      negi2_r <= ti[65];
      magr2_r <= tr[65] ? 64'(-tr) : tr[63:0];
      magi2_r <= ti[65] ? 64'(-ti) : ti[63:0];
      s2_r    <= 66'(p4_r + p5_r);
    end
  end

  logic [63:0]  mr;
  logic [63:0]  mi;
  cau_sat_t     satr;
  cau_sat_t     sati;
  logic [NW-1:0] nr;
  logic [NW-1:0] ni;
  logic [NW-1:0] hr;
  logic [NW-1:0] hi;
  logic [NW-1:0] den_ext;
  it_t          init;

  assign mr      = magr2_r >> FRAC_BITS;
  assign mi      = magi2_r >> FRAC_BITS;
  assign satr    = cau_sat(negr2_r, |mr[63:QBITS], mr[QBITS-1:0]);
  assign sati    = cau_sat(negi2_r, |mi[63:QBITS], mi[QBITS-1:0]);
  assign nr      = NW'(magr2_r) << FRAC_BITS;
  assign ni      = NW'(magi2_r) << FRAC_BITS;
  assign hr      = nr >> QBITS;
  assign hi      = ni >> QBITS;
  assign den_ext = NW'(s2_r[63:0]);

  always_comb begin
    init      = '0;
    init.kind = kind2_r;
    case (kind2_r)
      KIND_SUM: begin
        init.pr  = pr2_r;
        init.pi  = pi2_r;
        init.ovf = ovf2_r;
      end
      KIND_MUL: begin
        init.pr  = satr.val;
        init.pi  = sati.val;
        init.ovf = satr.ovf || sati.ovf;
      end
      default: ;
    endcase
    init.negr = negr2_r;
    init.negi = negi2_r;
    init.bigr = hr >= den_ext;
    init.bigi = hi >= den_ext;
    init.den  = s2_r[63:0];
    init.remr = hr[63:0];
    init.remi = hi[63:0];
    init.qnr  = nr[QBITS-1:0];
    init.qni  = ni[QBITS-1:0];
    init.sq   = SQ_W'(s2_r);
  end

  logic [QBITS:0] vi_r;
  it_t            it_r [QBITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r <= '0;
    end else if (en) begin
      vi_r <= {vi_r[QBITS-1:0], v2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= init;
      for (int k = 0; k < QBITS; k++) begin
        it_r[k+1] <= it_step(it_r[k]);
      end
    end
  end

  it_t      fin;
  cau_sat_t qr;
  cau_sat_t qi;
  cau_sat_t sd;

  assign fin = it_r[QBITS];
  assign qr  = cau_sat(fin.negr, fin.bigr, fin.qnr);
  assign qi  = cau_sat(fin.negi, fin.bigi, fin.qni);
  assign sd  = cau_sat(1'b0, 1'b0, fin.root);

  assign out_valid = vi_r[QBITS];

  always_comb begin
    out_item.result_real    = fin.pr;
    out_item.result_imag    = fin.pi;
    out_item.divide_by_zero = 1'b0;
    out_item.overflow       = fin.ovf;
    case (fin.kind)
      KIND_DIV: begin
        out_item.result_real = qr.val;
        out_item.result_imag = qi.val;
        out_item.overflow    = qr.ovf || qi.ovf;
      end
      KIND_DIST: begin
        out_item.result_real = sd.val;
        out_item.result_imag = 32'sd0;
        out_item.overflow    = sd.ovf;
      end
      KIND_DZ: begin
        out_item.result_real    = 32'sd0;
        out_item.result_imag    = 32'sd0;
        out_item.divide_by_zero = 1'b1;
        out_item.overflow       = 1'b0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/complex_arith_unit.sv
// Channel  Direction  Handshake             Beat
// in       input      in_push / in_full     cau_in_t: mode and two complex operands
// out      output     out_pop / out_empty   cau_out_t: result parts and flags
// One beat is accepted per cycle while in_full is low, and one result is delivered
// per cycle while out_empty is low and out_pop is high. A result passes through the
// input queue, the product, sum and setup stages, the 34-step quotient and root
// pipeline and the write into the result queue before it reaches the output ports.
// rst_n is synchronous; after reset both queues are empty.
// A full result queue freezes the back pipeline; the input queue then fills.
`default_nettype none
`include "complex_arith_unit_macros.svh"
module complex_arith_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  cau_in_t  in_data,
  output logic     out_empty,
  input  logic     out_pop,
  output cau_out_t out_data
);

  cau_mid_t mid_wr;
  cau_mid_t mid_rd;
  logic     mid_empty;
  logic     mid_pop;
  logic     en;
  logic     back_valid;
  cau_out_t back_item;
  logic     out_full;

  cau_front u_front (
    .item_i (in_data),
    .item_o (mid_wr)
  );

  cau_fifo #(.W($bits(cau_mid_t))) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (mid_wr),
    .full  (in_full),
    .pop   (mid_pop),
    .rdata (mid_rd),
    .empty (mid_empty)
  );

  assign en      = !(back_valid && out_full);
  assign mid_pop = en && !mid_empty;

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (!mid_empty),
    .in_item   (mid_rd),
    .out_valid (back_valid),
    .out_item  (back_item)
  );

  cau_fifo #(.W($bits(cau_out_t))) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (en && back_valid),
    .wdata (back_item),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

  `CAU_ASSERT_IMP(a_dz_clean, !out_empty && out_data.divide_by_zero, out_data.result_real == 32'sd0 && out_data.result_imag == 32'sd0 && !out_data.overflow, "Divide-by-zero result is not clean.")
  `CAU_ASSERT_NXT(a_stall_holds, back_valid && out_full, back_valid, "Stalled result was dropped.")
  `CAU_ASSERT_IMP(a_pop_room, mid_pop, !(back_valid && out_full), "Beat taken while back is stalled.")

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
module tb;
  import cau_pkg::*;

  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int RANDOM_BEATS = 830;
  localparam int CALM_FROM = 730;
  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef struct {
    cau_in_t  beat;
    bit       typed;
    cau_out_t result;
  } row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  cau_in_t  in_data = '0;
  logic     out_empty;
  logic     out_pop = 1'b0;
  cau_out_t out_data;

  cau_out_t pending_results[$];
  int errors = 0;
  int checked = 0;
  int mode_count[8];
  bit calm = 1'b0;

  complex_arith_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("FAIL complex_arith_unit");
    $finish;
  end

  function automatic logic [31:0] saturate(input logic neg, input logic [127:0] mag,
                                           inout logic ovf);
    if (!neg) begin
      if (mag > 128'h7FFF_FFFF) begin
        ovf = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 128'h8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return ~mag[31:0] + 32'd1;
  endfunction

  function automatic logic [127:0] magnitude(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic cau_out_t compute_result(input cau_in_t x);
    cau_out_t r;
    logic signed [127:0] ar, ai, br, bi, sr, si;
    logic [127:0] den, s, c, root;
    logic ovf;
    ar = x.a_real;
    ai = x.a_imag;
    br = x.b_real;
    bi = x.b_imag;
    ovf = 1'b0;
    r = '0;
    case (x.mode)
      MODE_ADD, MODE_SUB: begin
        sr = (x.mode == MODE_ADD) ? ar + br : ar - br;
        si = (x.mode == MODE_ADD) ? ai + bi : ai - bi;
        r.result_real = saturate(sr < 0, magnitude(sr), ovf);
        r.result_imag = saturate(si < 0, magnitude(si), ovf);
      end
      MODE_MUL: begin
        sr = ar * br - ai * bi;
        si = ar * bi + ai * br;
        r.result_real = saturate(sr < 0, magnitude(sr) >> FRAC, ovf);
        r.result_imag = saturate(si < 0, magnitude(si) >> FRAC, ovf);
      end
      MODE_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          sr = ar * br + ai * bi;
          si = ai * br - ar * bi;
          r.result_real = saturate(sr < 0, (magnitude(sr) << FRAC) / den, ovf);
          r.result_imag = saturate(si < 0, (magnitude(si) << FRAC) / den, ovf);
        end
      end
      MODE_DIST: begin
        sr = ar - br;
        si = ai - bi;
        s = sr * sr + si * si;
        root = '0;
        for (int k = 33; k >= 0; k--) begin
          c = root | (128'd1 << k);
          if (c * c <= s) root = c;
        end
        r.result_real = saturate(1'b0, root, ovf);
      end
      default: r = '0;
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return QMAX;
      1: return QMIN;
      2: return 32'(signed'($urandom_range(0, 4)) - 2);
      3, 4, 5: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      6, 7: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic cau_in_t random_beat();
    cau_in_t x;
    int r;
    r = $urandom_range(0, 19);
    x.mode = (r < 18) ? 3'(r % 5) : 3'(5 + $urandom_range(0, 2));
    x.a_real = pick_word();
    x.a_imag = pick_word();
    x.b_real = pick_word();
    x.b_imag = pick_word();
    if (x.mode == MODE_DIV && $urandom_range(0, 14) == 0) begin
      x.b_real = '0;
      x.b_imag = '0;
    end
    return x;
  endfunction

  task automatic send(input cau_in_t x, input cau_out_t result);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_data <= x;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    pending_results.push_back(result);
    mode_count[x.mode]++;
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic row_t mk(input logic [2:0] m, input logic [31:0] a, b, c, d,
                              input bit typed = 0, input logic [31:0] re = 0,
                              input logic [31:0] im = 0, input logic dz = 0,
                              input logic ov = 0);
    row_t w;
    w.beat = '{m, a, b, c, d};
    w.typed = typed;
    w.result = '{re, im, dz, ov};
    return w;
  endfunction

  initial begin
    row_t rows[$];
    cau_in_t x;
    rows.push_back(mk(MODE_ADD, ONE, ONE, ONE, ONE, 1, 32'h0002_0000, 32'h0002_0000));
    rows.push_back(mk(MODE_ADD, QMAX, QMIN, QMAX, QMIN, 1, QMAX, QMIN, 0, 1));
    rows.push_back(mk(MODE_SUB, QMIN, QMAX, QMAX, QMIN, 1, QMIN, QMAX, 0, 1));
    rows.push_back(mk(MODE_SUB, ONE, 0, ONE, 0, 1, 0, 0));
    rows.push_back(mk(MODE_MUL, ONE, 0, ONE, 0, 1, ONE, 0));
    rows.push_back(mk(MODE_MUL, QMAX, QMAX, QMAX, QMAX, 1, 0, QMAX, 0, 1));
    rows.push_back(mk(MODE_MUL, QMIN, QMIN, QMIN, QMIN));
    rows.push_back(mk(MODE_MUL, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF));
    rows.push_back(mk(MODE_DIV, QMAX, QMIN, 0, 0, 1, 0, 0, 1, 0));
    rows.push_back(mk(MODE_DIV, ONE, ONE, ONE, 0, 1, ONE, ONE));
    rows.push_back(mk(MODE_DIV, QMAX, QMAX, 1, 0, 1, QMAX, QMAX, 0, 1));
    rows.push_back(mk(MODE_DIV, QMIN, QMIN, QMIN, QMIN));
    rows.push_back(mk(MODE_DIV, 32'h0003_0000, 32'hFFFF_8000, 32'h0001_8000, 32'h0002_0000));
    rows.push_back(mk(MODE_DIST, 32'h0003_0000, 32'h0004_0000, 0, 0, 1, 32'h0005_0000, 0));
    rows.push_back(mk(MODE_DIST, QMAX, QMAX, QMIN, QMIN, 1, QMAX, 0, 0, 1));
    rows.push_back(mk(MODE_DIST, 0, 0, 0, 0, 1, 0, 0));
    rows.push_back(mk(MODE_DIST, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    rows.push_back(mk(MODE_SPARE5, QMAX, QMAX, 0, 0, 1, 0, 0));
    rows.push_back(mk(MODE_SPARE6, QMIN, 1, QMIN, 1, 1, 0, 0));
    rows.push_back(mk(MODE_SPARE7, 32'hFFFF_FFFF, QMAX, 0, 0, 1, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      x = rows[i].beat;
      send(x, rows[i].typed ? rows[i].result : compute_result(x));
    end
    wait_drained();
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      calm = (n >= CALM_FROM);
      x = random_beat();
      send(x, compute_result(x));
    end
    wait_drained();
    repeat (60) @(posedge clk);
    $display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d, dist %0d, spare %0d.",
             checked, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
             mode_count[4], mode_count[5] + mode_count[6] + mode_count[7]);
    if (errors == 0) begin
      $display("PASS complex_arith_unit");
    end else begin
      $display("FAIL complex_arith_unit");
    end
    $finish;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cau_out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (out_data.result_real !== want.result_real)
          $display("%0t: result_real expected %h actual %h", $time,
                   want.result_real, out_data.result_real);
        if (out_data.result_imag !== want.result_imag)
          $display("%0t: result_imag expected %h actual %h", $time,
                   want.result_imag, out_data.result_imag);
        if (out_data.divide_by_zero !== want.divide_by_zero)
          $display("%0t: divide_by_zero expected %b actual %b", $time,
                   want.divide_by_zero, out_data.divide_by_zero);
        if (out_data.overflow !== want.overflow)
          $display("%0t: overflow expected %b actual %b", $time,
                   want.overflow, out_data.overflow);
        if (out_data !== want) errors++;
      end
    end
  end

endmodule
